FILE: sv/rng_pkg.sv
// ----------------------------------------------------------------------------
// rng_pkg
// Shared types and constants for the radius neighbor graph block.
// ----------------------------------------------------------------------------
package rng_pkg;

  localparam int IDX_W        = 6;
  localparam int DEG_W        = 6;
  localparam int RADIUS_W     = 33;
  localparam int OUT_W        = 16;
  localparam int MAX_RESULTS  = 63;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 33'd57600;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESP,
    S_Q_RD,
    S_Q_CAP,
    S_PT_ADDR,
    S_PT_DIFF,
    S_PT_SQX,
    S_PT_SQY,
    S_PT_CMP,
    S_DONE
  } state_t;

  // Step controls for the shared distance unit.
  typedef struct packed {
    logic load_ref;
    logic load_diff;
    logic sq_x;
    logic sq_y;
  } dist_ctrl_t;

endpackage

FILE: sv/radius_neighbor_graph_top.sv
// ----------------------------------------------------------------------------
// radius_neighbor_graph_top
// Unit disk graph neighbor search over a stored set of fixed-point points.
// ----------------------------------------------------------------------------
// The block holds up to MAX_POINTS points with signed Q12.4 coordinates. A
// clear request empties the set, a load request appends one point (a load
// into a full set is dropped and answered with status "full"), and a query
// request names a node and returns, in ascending index order, one result for
// every other stored node whose squared distance is strictly below
// radius_sq; the final result of a query carries tlast and the degree. Clear,
// load, an out-of-range query and a query with no neighbors each return one
// empty result with tlast set, and command code three is ignored with no
// result. A query walks every stored point once through the single shared
// distance unit: for each other stored point it takes a memory read, the
// differences, each of the two squares on the one multiplier in turn, and
// the add and compare; the queried node itself is skipped, and acceptance,
// setup and finish are steps of their own. A stalled result channel can
// hold a query or a response. The block accepts a new request only when the
// previous one is done, but the last result may still wait in the output
// register. The radius_sq register may be written only while the block is
// idle.
// ----------------------------------------------------------------------------
module radius_neighbor_graph_top #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16,
  localparam int IN_W = ((2 * COORD_BITS + rng_pkg::IDX_W + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Request channel.
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // in_tdata, from bit 0: coord_x, coord_y, node_index, zero padding.
  input  logic [IN_W-1:0]              in_tdata,
  // in_tuser: cmd.
  input  logic [1:0]                   in_tuser,
  // Result channel.
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // out_tdata, from bit 0: neighbor, degree, status, zero padding.
  output logic [rng_pkg::OUT_W-1:0]    out_tdata,
  // out_tuser: has_neighbor.
  output logic                         out_tuser,
  output logic                         out_tlast,
  // Configuration write channel for radius_sq.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rng_pkg::RADIUS_W-1:0] cfg_data
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int NW = (CW > rng_pkg::IDX_W) ? CW : rng_pkg::IDX_W;
  localparam int IW = rng_pkg::IDX_W;
  localparam int GW = rng_pkg::DEG_W;

  // Request fields.
  logic [COORD_BITS-1:0] in_x, in_y;
  logic [IW-1:0]         in_node;
  rng_pkg::cmd_t         in_cmd;

  assign in_x    = in_tdata[COORD_BITS-1:0];
  assign in_y    = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_node = in_tdata[2*COORD_BITS+IW-1:2*COORD_BITS];
  assign in_cmd  = rng_pkg::cmd_t'(in_tuser);

  // Control and payload registers.
  rng_pkg::state_t             state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               j_r, j_nxt;
  logic [GW-1:0]               deg_r, deg_nxt;
  logic [AW-1:0]               node_r, node_nxt;
  rng_pkg::status_t            status_r, status_nxt;
  logic                        pend_valid_r, pend_valid_nxt;
  logic [IW-1:0]               pend_nb_r, pend_nb_nxt;
  logic [GW-1:0]               pend_deg_r, pend_deg_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [IW-1:0]               out_nb_r, out_nb_nxt;
  logic                        out_has_r, out_has_nxt;
  logic [GW-1:0]               out_deg_r, out_deg_nxt;
  logic                        out_last_r, out_last_nxt;
  rng_pkg::status_t            out_st_r, out_st_nxt;
  logic [rng_pkg::RADIUS_W-1:0] radius_r;

  logic accept, full, node_ok, out_free, hit, push, mem_we;
  logic [AW-1:0]               raddr;
  logic [2*COORD_BITS-1:0]     rdata;
  rng_pkg::dist_ctrl_t         dctrl;

  assign accept   = in_tvalid && in_tready;
  assign full     = count_r >= CW'(MAX_POINTS);
  assign node_ok  = NW'(in_node) < NW'(count_r);
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == rng_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // The memory read port serves the queried node during setup and the
  // scanned point otherwise.
  assign raddr  = (state_r == rng_pkg::S_Q_RD) ? node_r : AW'(j_r);
  assign mem_we = accept && (in_cmd == rng_pkg::CMD_LOAD) && !full;

  rng_point_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW),
    .DW    (2 * COORD_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(count_r)),
    .wdata ({in_y, in_x}),
    .raddr (raddr),
    .rdata (rdata)
  );

  rng_dist_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk    (clk),
    .ctrl   (dctrl),
    .rd_x   (rdata[COORD_BITS-1:0]),
    .rd_y   (rdata[2*COORD_BITS-1:COORD_BITS]),
    .radius (radius_r),
    .hit    (hit)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rng_pkg::S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            rng_pkg::CMD_CLEAR: state_nxt = rng_pkg::S_RESP;
            rng_pkg::CMD_LOAD:  state_nxt = rng_pkg::S_RESP;
            rng_pkg::CMD_QUERY: state_nxt = node_ok ? rng_pkg::S_Q_RD : rng_pkg::S_RESP;
            default:            state_nxt = rng_pkg::S_IDLE;
          endcase
        end
      end
      rng_pkg::S_RESP: begin
        if (out_free) state_nxt = rng_pkg::S_IDLE;
      end
      rng_pkg::S_Q_RD:  state_nxt = rng_pkg::S_Q_CAP;
      rng_pkg::S_Q_CAP: state_nxt = rng_pkg::S_PT_ADDR;
      rng_pkg::S_PT_ADDR: begin
        if (j_r >= count_r || deg_r == GW'(rng_pkg::MAX_RESULTS)) begin
          state_nxt = rng_pkg::S_DONE;
        end else if (j_r != CW'(node_r)) begin
          state_nxt = rng_pkg::S_PT_DIFF;
        end
      end
      rng_pkg::S_PT_DIFF: state_nxt = rng_pkg::S_PT_SQX;
      rng_pkg::S_PT_SQX:  state_nxt = rng_pkg::S_PT_SQY;
      rng_pkg::S_PT_SQY:  state_nxt = rng_pkg::S_PT_CMP;
      rng_pkg::S_PT_CMP: begin
        if (!(hit && pend_valid_r && !out_free)) state_nxt = rng_pkg::S_PT_ADDR;
      end
      rng_pkg::S_DONE: begin
        if (out_free) state_nxt = rng_pkg::S_IDLE;
      end
      default: state_nxt = rng_pkg::S_IDLE;
    endcase
  end

  // Datapath and result control.
  always_comb begin
    count_nxt      = count_r;
    j_nxt          = j_r;
    deg_nxt        = deg_r;
    node_nxt       = node_r;
    status_nxt     = status_r;
    pend_valid_nxt = pend_valid_r;
    pend_nb_nxt    = pend_nb_r;
    pend_deg_nxt   = pend_deg_r;
    dctrl          = '0;
    push           = 1'b0;
    out_nb_nxt     = out_nb_r;
    out_has_nxt    = out_has_r;
    out_deg_nxt    = out_deg_r;
    out_last_nxt   = out_last_r;
    out_st_nxt     = out_st_r;
    case (state_r)
      rng_pkg::S_IDLE: begin
        if (accept) begin
          status_nxt = rng_pkg::ST_OK;
          j_nxt      = '0;
          deg_nxt    = '0;
          node_nxt   = AW'(in_node);
          case (in_cmd)
            rng_pkg::CMD_CLEAR: count_nxt = '0;
            rng_pkg::CMD_LOAD: begin
              if (full) begin
                status_nxt = rng_pkg::ST_FULL;
              end else begin
                count_nxt = count_r + CW'(1);
              end
            end
            rng_pkg::CMD_QUERY: begin
              if (!node_ok) status_nxt = rng_pkg::ST_RANGE;
            end
            default: ;
          endcase
        end
      end
      rng_pkg::S_RESP: begin
        if (out_free) begin
          push         = 1'b1;
          out_nb_nxt   = '0;
          out_has_nxt  = 1'b0;
          out_deg_nxt  = '0;
          out_last_nxt = 1'b1;
          out_st_nxt   = status_r;
        end
      end
      rng_pkg::S_Q_CAP: dctrl.load_ref = 1'b1;
      rng_pkg::S_PT_ADDR: begin
        // The queried node itself is skipped here.
        if (j_r < count_r && deg_r != GW'(rng_pkg::MAX_RESULTS) && j_r == CW'(node_r)) begin
          j_nxt = j_r + CW'(1);
        end
      end
      rng_pkg::S_PT_DIFF: dctrl.load_diff = 1'b1;
      rng_pkg::S_PT_SQX:  dctrl.sq_x = 1'b1;
      rng_pkg::S_PT_SQY:  dctrl.sq_y = 1'b1;
      rng_pkg::S_PT_CMP: begin
        if (hit) begin
          // A new neighbor pushes the held one out; the newest one is held
          // back until we know whether it is the last.
          if (!pend_valid_r || out_free) begin
            if (pend_valid_r) begin
              push         = 1'b1;
              out_nb_nxt   = pend_nb_r;
              out_has_nxt  = 1'b1;
              out_deg_nxt  = pend_deg_r;
              out_last_nxt = 1'b0;
              out_st_nxt   = rng_pkg::ST_OK;
            end
            pend_valid_nxt = 1'b1;
            pend_nb_nxt    = IW'(j_r);
            pend_deg_nxt   = deg_r + GW'(1);
            deg_nxt        = deg_r + GW'(1);
            j_nxt          = j_r + CW'(1);
          end
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      rng_pkg::S_DONE: begin
        if (out_free) begin
          push           = 1'b1;
          out_nb_nxt     = pend_valid_r ? pend_nb_r : '0;
          out_has_nxt    = pend_valid_r;
          out_deg_nxt    = pend_valid_r ? pend_deg_r : '0;
          out_last_nxt   = 1'b1;
          out_st_nxt     = rng_pkg::ST_OK;
          pend_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
    out_valid_nxt = push || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rng_pkg::S_IDLE;
      count_r      <= '0;
      j_r          <= '0;
      deg_r        <= '0;
      status_r     <= rng_pkg::ST_OK;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      radius_r     <= rng_pkg::RADIUS_RESET;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      j_r          <= j_nxt;
      deg_r        <= deg_nxt;
      status_r     <= status_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        radius_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    pend_nb_r  <= pend_nb_nxt;
    pend_deg_r <= pend_deg_nxt;
    out_nb_r   <= out_nb_nxt;
    out_has_r  <= out_has_nxt;
    out_deg_r  <= out_deg_nxt;
    out_last_r <= out_last_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_st_r, out_deg_r, out_nb_r};
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_last_r;

  // The point count never runs past the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS))
    else $error("point count exceeds store depth");

  // A held neighbor always carries a nonzero degree.
  a_pend_degree: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> pend_deg_r != '0)
    else $error("held neighbor has zero degree");

  // The queried node is never compared against itself.
  a_skip_self: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rng_pkg::S_PT_DIFF |-> j_r != CW'(node_r))
    else $error("queried node scanned as its own neighbor");

  // A clear request empties the set.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_cmd == rng_pkg::CMD_CLEAR |=> count_r == '0)
    else $error("clear did not empty the set");

  // A load into a set with room adds exactly one point.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_cmd == rng_pkg::CMD_LOAD && !full |=> count_r == $past(count_r) + CW'(1))
    else $error("load did not advance the point count");

endmodule

FILE: sv/rng_point_mem.sv
// ----------------------------------------------------------------------------
// rng_point_mem
// Point store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rng_point_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/rng_dist_unit.sv
// ----------------------------------------------------------------------------
// rng_dist_unit
// Shared squared-distance unit: one subtract stage, one multiplier used for
// both axes in turn, and a final add and compare against the radius.
// ----------------------------------------------------------------------------
module rng_dist_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  rng_pkg::dist_ctrl_t           ctrl,
  input  logic [COORD_BITS-1:0]         rd_x,
  input  logic [COORD_BITS-1:0]         rd_y,
  input  logic [rng_pkg::RADIUS_W-1:0]  radius,
  output logic                          hit
);

  localparam int PW = 2 * COORD_BITS;
  localparam int SW = (PW + 1 > rng_pkg::RADIUS_W) ? PW + 1 : rng_pkg::RADIUS_W;

  logic [COORD_BITS-1:0] ref_x_r, ref_y_r;
  logic [COORD_BITS-1:0] dx_r, dy_r;
  logic [PW-1:0]         sx_r, sy_r;

  logic signed [COORD_BITS:0] diff_x, diff_y;
  logic [COORD_BITS:0]        mag_x, mag_y;
  logic [COORD_BITS-1:0]      mul_op;
  logic [PW-1:0]              prod;
  logic [SW-1:0]              sum;

  // Differences are formed one bit wider so they cannot wrap.
  assign diff_x = $signed({rd_x[COORD_BITS-1], rd_x}) - $signed({ref_x_r[COORD_BITS-1], ref_x_r});
  assign diff_y = $signed({rd_y[COORD_BITS-1], rd_y}) - $signed({ref_y_r[COORD_BITS-1], ref_y_r});
  assign mag_x  = diff_x[COORD_BITS] ? (COORD_BITS+1)'(-diff_x) : diff_x;
  assign mag_y  = diff_y[COORD_BITS] ? (COORD_BITS+1)'(-diff_y) : diff_y;

  assign mul_op = ctrl.sq_y ? dy_r : dx_r;
  assign prod   = PW'(mul_op) * PW'(mul_op);

  // The sum is at least one bit wider than a square, so the exact sum always
  // fits and never needs saturation.
  assign sum = SW'(sx_r) + SW'(sy_r);
  assign hit = sum < SW'(radius);

  always_ff @(posedge clk) begin
    if (ctrl.load_ref) begin
      ref_x_r <= rd_x;
      ref_y_r <= rd_y;
    end
    if (ctrl.load_diff) begin
      dx_r <= mag_x[COORD_BITS-1:0];
      dy_r <= mag_y[COORD_BITS-1:0];
    end
    if (ctrl.sq_x) begin
      sx_r <= prod;
    end
    if (ctrl.sq_y) begin
      sy_r <= prod;
    end
  end

endmodule

FILE: tb/radius_neighbor_graph_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radius_neighbor_graph_top_tb
// Self-checking bench for the radius neighbor graph block.
// ----------------------------------------------------------------------------
// Requests are queued by a sequencing initial block and put on the stream by a
// clocked driver. A monitor on the rising edge mirrors every accepted request
// into a local copy of the point set and radius, derives the neighbor results
// it must produce, and compares each returned result against the oldest one.
// The run starts with a short directed set (boundary distances, extreme
// coordinates, last-node and out-of-range queries, the ignored command). It
// then fills the set to the top under a full-scale radius while the receiver
// holds off. After that come clustered random runs under zero, unit, random
// and default radius settings, with several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module radius_neighbor_graph_top_tb;

  localparam int COORD_W      = 16;
  localparam int SET_SIZE     = 64;
  localparam int IN_W         = ((2 * COORD_W + rng_pkg::IDX_W + 7) / 8) * 8;
  // Settle for longer than a query over a full set takes.
  localparam int SETTLE_CYCLES  = 400;
  localparam int RX_HOLD_CYCLES = 800;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int MAX_PRINTED    = 100;
  // Command code three is not a real command; the block must ignore it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [rng_pkg::RADIUS_W-1:0] RADIUS_FULL_SCALE = {rng_pkg::RADIUS_W{1'b1}};

  typedef struct {
    logic [1:0]                cmd;
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
    logic [rng_pkg::IDX_W-1:0] node;
  } request_t;

  typedef struct {
    logic [rng_pkg::IDX_W-1:0] neighbor;
    logic                      has_neighbor;
    logic [rng_pkg::DEG_W-1:0] degree;
    logic                      last;
    rng_pkg::status_t          status;
  } neighbor_result_t;

  // Clock and reset. Reset is applied once, at the start of the run.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  // Block inputs, all at known values from time zero.
  logic                         in_tvalid  = 1'b0;
  logic [IN_W-1:0]              in_tdata   = '0;
  logic [1:0]                   in_tuser   = '0;
  logic                         out_tready = 1'b0;
  logic                         cfg_valid  = 1'b0;
  logic [rng_pkg::RADIUS_W-1:0] cfg_data   = '0;

  logic                         in_tready;
  logic                         out_tvalid;
  logic [rng_pkg::OUT_W-1:0]    out_tdata;
  logic                         out_tuser;
  logic                         out_tlast;
  logic                         cfg_ready;

  radius_neighbor_graph_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Stimulus queue, expected results and the local copy of the block's state.
  request_t         pending_requests[$];
  neighbor_result_t expected_results[$];
  logic signed [COORD_W-1:0] point_x [SET_SIZE];
  logic signed [COORD_W-1:0] point_y [SET_SIZE];
  int                           point_total   = 0;
  logic [rng_pkg::RADIUS_W-1:0] radius_shadow = rng_pkg::RADIUS_RESET;

  // Idling mix, in percent, and the long receiver hold-off.
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  logic        hold_trigger = 1'b0;
  logic        hold_seen    = 1'b0;
  int unsigned hold_left    = 0;

  // Handshake flags sampled on the rising edge, used on the falling edge.
  logic in_took  = 1'b0;
  logic cfg_took = 1'b0;

  int error_count     = 0;
  int cycle_count     = 0;
  int request_count   = 0;
  int query_count     = 0;
  int neighbor_count  = 0;
  int result_count    = 0;
  int full_drop_count = 0;

  request_t         drive_req;
  neighbor_result_t want;

  task automatic report_mismatch(input string what, input longint got, input longint exp_val);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, exp_val);
  endtask

  // Mirror one accepted request and append the results it must produce.
  task automatic apply_request(input logic [1:0] cmd, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y,
                               input logic [rng_pkg::IDX_W-1:0] node);
    int               hits[$];
    longint           dx;
    longint           dy;
    longint           sq_dist;
    neighbor_result_t r;
    r = '{neighbor: '0, has_neighbor: 1'b0, degree: '0, last: 1'b1, status: rng_pkg::ST_OK};
    case (cmd)
      rng_pkg::CMD_CLEAR: begin
        point_total = 0;
        expected_results.insert(expected_results.size(), r);
      end
      rng_pkg::CMD_LOAD: begin
        if (point_total >= SET_SIZE) begin
          r.status = rng_pkg::ST_FULL;
          full_drop_count++;
        end else begin
          point_x[point_total] = x;
          point_y[point_total] = y;
          point_total++;
        end
        expected_results.insert(expected_results.size(), r);
      end
      rng_pkg::CMD_QUERY: begin
        query_count++;
        if (int'(node) >= point_total) begin
          r.status = rng_pkg::ST_RANGE;
          expected_results.insert(expected_results.size(), r);
        end else begin
          for (int j = 0; j < point_total; j++) begin
            if (j != int'(node)) begin
              dx = longint'(point_x[node]) - longint'(point_x[j]);
              dy = longint'(point_y[node]) - longint'(point_y[j]);
              if (dx < 0) dx = -dx;
              if (dy < 0) dy = -dy;
              sq_dist = dx * dx + dy * dy;
              if (sq_dist < longint'(radius_shadow) && hits.size() < rng_pkg::MAX_RESULTS)
                hits.insert(hits.size(), j);
            end
          end
          if (hits.size() == 0) begin
            expected_results.insert(expected_results.size(), r);
          end else begin
            // Neighbors come out in ascending index order with a running degree.
            foreach (hits[k]) begin
              r.neighbor     = hits[k][rng_pkg::IDX_W-1:0];
              r.has_neighbor = 1'b1;
              r.degree       = rng_pkg::DEG_W'(k + 1);
              r.last         = (k == hits.size() - 1);
              expected_results.insert(expected_results.size(), r);
            end
            neighbor_count++;
          end
        end
      end
      default: begin
        // The unused command leaves the state alone and produces nothing.
      end
    endcase
  endtask

  // Rising edge: sample both streams and the configuration channel.
  always @(posedge clk) begin
    in_took  = rst_n && in_tvalid && in_tready;
    cfg_took = rst_n && cfg_valid && cfg_ready;
    if (cfg_took)
      radius_shadow = cfg_data;
    if (in_took) begin
      request_count++;
      apply_request(in_tuser, in_tdata[15:0], in_tdata[31:16], in_tdata[37:32]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected, tdata", longint'(out_tdata), 0);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[5:0] !== want.neighbor)
          report_mismatch("neighbor", longint'(out_tdata[5:0]), longint'(want.neighbor));
        if (out_tuser !== want.has_neighbor)
          report_mismatch("has_neighbor", longint'(out_tuser), longint'(want.has_neighbor));
        if (out_tdata[11:6] !== want.degree)
          report_mismatch("degree", longint'(out_tdata[11:6]), longint'(want.degree));
        if (out_tlast !== want.last)
          report_mismatch("last", longint'(out_tlast), longint'(want.last));
        if (out_tdata[13:12] !== want.status)
          report_mismatch("status", longint'(out_tdata[13:12]), longint'(want.status));
      end
    end
  end

  // Request driver. A new request is only put up once the current one has been
  // taken, so tvalid sees a single update per falling edge.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        drive_req = pending_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= drive_req.cmd;
        in_tdata  <= {{(IN_W - 2 * COORD_W - rng_pkg::IDX_W){1'b0}},
                      drive_req.node, drive_req.y, drive_req.x};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here. A toggle of hold_trigger starts it.
  always @(negedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= RX_HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result receiver with random back-pressure.
  always @(negedge clk) begin
    if (!rst_n || hold_left != 0 || hold_trigger != hold_seen)
      out_tready <= 1'b0;
    else
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped by the watchdog after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_request(input logic [1:0] cmd, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y,
                               input logic [rng_pkg::IDX_W-1:0] node);
    request_t r;
    r = '{cmd: cmd, x: x, y: y, node: node};
    pending_requests.insert(pending_requests.size(), r);
  endtask

  // Changes take effect on a rising edge so that the falling-edge processes
  // never race with them.
  task automatic set_idling(input int tx_pct, input int rx_pct);
    @(posedge clk);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // Wait until every request is out and answered, then leave the block idle
  // for a while before anything is reconfigured.
  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_radius(input logic [rng_pkg::RADIUS_W-1:0] value);
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  // One well-formed run: clear, then loads scattered around a random center
  // mixed with queries, plus the odd stray query and ignored command.
  task automatic cluster_run(input int n_loads, input int n_queries, input int spread);
    logic [COORD_W-1:0]        cx;
    logic [COORD_W-1:0]        cy;
    logic [COORD_W-1:0]        px;
    logic [COORD_W-1:0]        py;
    logic [rng_pkg::IDX_W-1:0] idx;
    int loads_left;
    int queries_left;
    int stored;
    int pick;
    cx           = COORD_W'($urandom);
    cy           = COORD_W'($urandom);
    px           = cx;
    py           = cy;
    loads_left   = n_loads;
    queries_left = n_queries;
    stored       = 0;
    queue_request(rng_pkg::CMD_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
                  rng_pkg::IDX_W'($urandom));
    while (loads_left + queries_left > 0) begin
      if ($urandom_range(0, 11) == 0)
        queue_request(CMD_UNUSED, COORD_W'($urandom), COORD_W'($urandom),
                      rng_pkg::IDX_W'($urandom));
      if (loads_left > 0 && (queries_left == 0 || stored == 0 || $urandom_range(0, 2) != 0)) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          px = COORD_W'($urandom);
          py = COORD_W'($urandom);
        end else if (pick != 1 || stored == 0) begin
          // Apart from random points and repeats of the previous point, loads stay near the center.
          px = cx + COORD_W'($urandom_range(0, 2 * spread) - spread);
          py = cy + COORD_W'($urandom_range(0, 2 * spread) - spread);
        end
        queue_request(rng_pkg::CMD_LOAD, px, py, rng_pkg::IDX_W'($urandom));
        stored++;
        loads_left--;
      end else begin
        if ($urandom_range(0, 7) == 0)
          idx = rng_pkg::IDX_W'($urandom_range(0, SET_SIZE - 1));
        else
          idx = rng_pkg::IDX_W'($urandom_range(0, stored - 1));
        queue_request(rng_pkg::CMD_QUERY, COORD_W'($urandom), COORD_W'($urandom), idx);
        queries_left--;
      end
    end
  endtask

  int rad;

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part under the reset radius of fifteen (240 raw units).
    set_idling(0, 0);
    queue_request(rng_pkg::CMD_QUERY, 16'h0000, 16'h0000, 6'd0);   // empty set: out of range
    queue_request(rng_pkg::CMD_CLEAR, 16'h0000, 16'h0000, 6'd0);
    queue_request(rng_pkg::CMD_LOAD,  16'd0,    16'd0,    6'd0);   // node 0
    queue_request(rng_pkg::CMD_LOAD,  16'd239,  16'd0,    6'd0);   // just inside from node 0
    queue_request(rng_pkg::CMD_LOAD,  16'd240,  16'd0,    6'd0);   // exactly on the radius
    queue_request(rng_pkg::CMD_LOAD,  16'h8000, 16'h8000, 6'd0);   // extreme corners
    queue_request(rng_pkg::CMD_LOAD,  16'h7FFF, 16'h7FFF, 6'd0);
    queue_request(rng_pkg::CMD_LOAD,  16'h8000, 16'h7FFF, 6'd0);
    queue_request(rng_pkg::CMD_LOAD,  16'h7FFF, 16'h8000, 6'd0);
    queue_request(rng_pkg::CMD_QUERY, 16'hFFFF, 16'hFFFF, 6'd0);
    queue_request(rng_pkg::CMD_QUERY, 16'h0000, 16'h0000, 6'd1);
    queue_request(rng_pkg::CMD_QUERY, 16'h0000, 16'h0000, 6'd2);
    queue_request(rng_pkg::CMD_QUERY, 16'h0000, 16'h0000, 6'd3);   // isolated corner
    queue_request(rng_pkg::CMD_QUERY, 16'h0000, 16'h0000, 6'd6);   // last stored node
    queue_request(rng_pkg::CMD_QUERY, 16'h0000, 16'h0000, 6'd7);   // one past the end
    queue_request(rng_pkg::CMD_QUERY, 16'h0000, 16'h0000, 6'd63);
    queue_request(CMD_UNUSED,         16'hFFFF, 16'hFFFF, 6'd63);  // ignored
    queue_request(rng_pkg::CMD_LOAD,  16'hFFFF, 16'hFFFF, 6'd63);  // minus one, near node 0
    queue_request(rng_pkg::CMD_LOAD,  16'h5555, 16'hAAAA, 6'h2A);
    queue_request(rng_pkg::CMD_QUERY, 16'h0000, 16'h0000, 6'd7);
    queue_request(rng_pkg::CMD_CLEAR, 16'hFFFF, 16'hFFFF, 6'd63);
    queue_request(rng_pkg::CMD_QUERY, 16'h0000, 16'h0000, 6'd0);   // cleared: out of range
    queue_request(rng_pkg::CMD_LOAD,  16'd5,    16'd5,    6'd0);
    queue_request(rng_pkg::CMD_QUERY, 16'h0000, 16'h0000, 6'd0);   // lone point
    wait_idle();

    // Full set under the full-scale radius: every other node is a neighbor,
    // so each query returns the most results the block can give. The
    // receiver holds off at the start so the block backs up into its input.
    write_radius(RADIUS_FULL_SCALE);
    set_idling(0, 0);
    hold_trigger = ~hold_trigger;
    queue_request(rng_pkg::CMD_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
                  rng_pkg::IDX_W'($urandom));
    for (int i = 0; i < SET_SIZE; i++)
      queue_request(rng_pkg::CMD_LOAD, COORD_W'($urandom), COORD_W'($urandom),
                    rng_pkg::IDX_W'($urandom));
    // The set is full now, so these two loads are dropped.
    queue_request(rng_pkg::CMD_LOAD, COORD_W'($urandom), COORD_W'($urandom),
                  rng_pkg::IDX_W'($urandom));
    queue_request(rng_pkg::CMD_LOAD, COORD_W'($urandom), COORD_W'($urandom),
                  rng_pkg::IDX_W'($urandom));
    queue_request(rng_pkg::CMD_QUERY, COORD_W'($urandom), COORD_W'($urandom), 6'd0);
    queue_request(rng_pkg::CMD_QUERY, COORD_W'($urandom), COORD_W'($urandom), 6'd63);
    queue_request(rng_pkg::CMD_QUERY, COORD_W'($urandom), COORD_W'($urandom),
                  rng_pkg::IDX_W'($urandom));
    queue_request(rng_pkg::CMD_QUERY, COORD_W'($urandom), COORD_W'($urandom),
                  rng_pkg::IDX_W'($urandom));
    wait_idle();

    // Zero radius: nothing is ever strictly closer, so every query is empty.
    write_radius('0);
    set_idling(68, 0);
    cluster_run(6, 4, 300);
    wait_idle();

    rad = $urandom_range(16, 3000);
    write_radius(rng_pkg::RADIUS_W'(rad * rad + $urandom_range(0, rad)));
    set_idling(0, 68);
    cluster_run(8, 6, 2 * rad);
    wait_idle();

    rad = $urandom_range(16, 3000);
    write_radius(rng_pkg::RADIUS_W'(rad * rad + $urandom_range(0, rad)));
    set_idling(38, 38);
    cluster_run(8, 6, 2 * rad);
    wait_idle();

    // Unit radius: only coincident points are neighbors.
    write_radius(rng_pkg::RADIUS_W'(1));
    set_idling(38, 38);
    cluster_run(6, 4, 2);
    wait_idle();

    write_radius(rng_pkg::RADIUS_RESET);
    set_idling(0, 0);
    cluster_run(6, 4, 300);
    wait_idle();

    $display("Covered %0d requests: %0d queries (%0d with neighbors), %0d results checked.",
             request_count, query_count, neighbor_count, result_count);
    $display("Radius settings zero, one, default, full scale and random; %0d loads dropped.",
             full_drop_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("Failures: %0d mismatches, %0d results never returned",
               error_count, expected_results.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: radius_neighbor_graph_top.f
sv/rng_pkg.sv
sv/rng_point_mem.sv
sv/rng_dist_unit.sv
sv/radius_neighbor_graph_top.sv
tb/radius_neighbor_graph_top_tb.sv
